### hw/rtl/toroidal_min_path_emitter_core_macros.svh
// assertion macros shared by the emitter modules
// no dependencies; taken in by `include where assertions are written
`ifndef TOROIDAL_MIN_PATH_EMITTER_CORE_MACROS_SVH
`define TOROIDAL_MIN_PATH_EMITTER_CORE_MACROS_SVH

// condition holds at every edge outside reset
`define TMPE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TMPE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define TMPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/tmpe_pkg.sv
// shared types and constants of the toroidal shortest path emitter
// no dependencies; used by the controller, the datapath and the top level
package tmpe_pkg;

    // fixed field widths
    localparam int POS_W     = 10;
    localparam int QIDX_W    = 11;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

    // register reset values and dimension floor
    localparam logic [CFG_W-1:0] ROW_RESET = 6'd8;
    localparam logic [CFG_W-1:0] COL_RESET = 6'd8;
    localparam int MIN_DIM = 2;

    // default lattice limits
    localparam int DEF_MAX_ROWS = 32;
    localparam int DEF_MAX_COLS = 32;

    // result cap per path
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // divider operations, in issue order
    localparam logic [1:0] OP_X_BY_COLS = 2'd0;
    localparam logic [1:0] OP_Y_BY_COLS = 2'd1;
    localparam logic [1:0] OP_X_ROW_MOD = 2'd2;
    localparam logic [1:0] OP_Y_ROW_MOD = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       div_start;
        logic       div_cap;
        logic [1:0] div_op;
        logic       setup;
        logic       step;
        logic       adv;
        logic       flush;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic has;
        logic last_seg;
        logic full;
    } t_sts;

endpackage

### hw/rtl/tmpe_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on nothing but its parameters
module tmpe_div #(
    parameter int DVD_W = 10,
    parameter int DVS_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot,
    output logic [DVS_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quot;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   n_sh;
    logic [DVS_W:0]   n_diff;
    logic             n_ge;

    // trial subtract of the shifted partial remainder
    always_comb begin
        n_sh   = {r_rem, r_quot[DVD_W-1]};
        n_ge   = n_sh >= {1'b0, r_dvs};
        n_diff = n_sh - {1'b0, r_dvs};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DVD_W-2:0], n_ge};
            r_rem  <= n_ge ? n_diff[DVS_W-1:0] : n_sh[DVS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

### hw/rtl/tmpe_dp.sv
// datapath: config registers, position split, route segments, index generation
// depends on tmpe_pkg, tmpe_div and the assertion macro header
`include "toroidal_min_path_emitter_core_macros.svh"

module tmpe_dp #(
    parameter int MAX_ROWS = tmpe_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = tmpe_pkg::DEF_MAX_COLS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [tmpe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tmpe_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic [tmpe_pkg::POS_W-1:0]   i_first_pos,
    input  logic [tmpe_pkg::POS_W-1:0]   i_second_pos,
    input  tmpe_pkg::t_cmd               i_cmd,
    output tmpe_pkg::t_sts               o_sts,
    output logic                         o_valid,
    output logic [tmpe_pkg::QIDX_W-1:0]  o_qubit_index,
    output logic                         o_last
);

    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int COL_W = $clog2(MAX_COLS + 1);
    localparam int DIM_W = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int V_W   = 2 * DIM_W + 2;
    localparam int POS_W = tmpe_pkg::POS_W;
    localparam int QW    = tmpe_pkg::QIDX_W;
    localparam int CW    = tmpe_pkg::CNT_W;

    // config registers
    logic [tmpe_pkg::CFG_W-1:0] r_rows;
    logic [tmpe_pkg::CFG_W-1:0] r_cols;

    // transaction operands and split results
    logic [POS_W-1:0] r_x;
    logic [POS_W-1:0] r_y;
    logic [POS_W-1:0] r_qx;
    logic [POS_W-1:0] r_qy;
    logic [DIM_W-1:0] r_cx;
    logic [DIM_W-1:0] r_cy;
    logic [DIM_W-1:0] r_rx;
    logic [DIM_W-1:0] r_ry;

    // segment queue and walk state
    logic [DIM_W-1:0] r_st [4];
    logic [DIM_W-1:0] r_en [4];
    logic [DIM_W-1:0] r_k;
    logic [1:0]       r_seg;
    logic [V_W-1:0]   r_hbase;
    logic [CW-1:0]    r_cnt;

    // one-deep hold so the final result can be flagged
    logic [QW-1:0]    r_pend;
    logic             r_pend_v;
    logic [QW-1:0]    r_out;
    logic             r_out_v;
    logic             r_out_last;

    logic [DIM_W-1:0] n_nr;
    logic [DIM_W-1:0] n_nc;
    logic [POS_W-1:0] n_dvd;
    logic [DIM_W-1:0] n_dvs;
    logic             n_done;
    logic [POS_W-1:0] n_quot;
    logic [DIM_W-1:0] n_rem;
    logic [DIM_W-1:0] n_rlo;
    logic [DIM_W-1:0] n_rhi;
    logic [DIM_W-1:0] n_clo;
    logic [DIM_W-1:0] n_chi;
    logic [DIM_W:0]   n_vd2;
    logic [DIM_W:0]   n_hd2;
    logic             n_vdir;
    logic             n_hdir;
    logic [DIM_W-1:0] n_st [4];
    logic [DIM_W-1:0] n_en [4];
    logic [V_W-1:0]   n_hbase;
    logic [V_W-1:0]   n_val;

    // config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= tmpe_pkg::ROW_RESET;
            r_cols <= tmpe_pkg::COL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tmpe_pkg::REG_ROW_COUNT: r_rows <= i_cfg_data;
                tmpe_pkg::REG_COL_COUNT: r_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp dimensions into the supported range
    always_comb begin
        if (32'(r_rows) < tmpe_pkg::MIN_DIM) begin
            n_nr = DIM_W'(tmpe_pkg::MIN_DIM);
        end else if (32'(r_rows) > MAX_ROWS) begin
            n_nr = DIM_W'(MAX_ROWS);
        end else begin
            n_nr = DIM_W'(r_rows);
        end
        if (32'(r_cols) < tmpe_pkg::MIN_DIM) begin
            n_nc = DIM_W'(tmpe_pkg::MIN_DIM);
        end else if (32'(r_cols) > MAX_COLS) begin
            n_nc = DIM_W'(MAX_COLS);
        end else begin
            n_nc = DIM_W'(r_cols);
        end
    end

    // divider operand select
    always_comb begin
        case (i_cmd.div_op)
            tmpe_pkg::OP_X_BY_COLS: begin
                n_dvd = r_x;
                n_dvs = n_nc;
            end
            tmpe_pkg::OP_Y_BY_COLS: begin
                n_dvd = r_y;
                n_dvs = n_nc;
            end
            tmpe_pkg::OP_X_ROW_MOD: begin
                n_dvd = r_qx;
                n_dvs = n_nr;
            end
            default: begin
                n_dvd = r_qy;
                n_dvs = n_nr;
            end
        endcase
    end

    tmpe_div #(
        .DVD_W (POS_W),
        .DVS_W (DIM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (n_dvd),
        .i_divisor  (n_dvs),
        .o_done     (n_done),
        .o_quot     (n_quot),
        .o_rem      (n_rem)
    );

    // operand capture and divider results
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_first_pos;
            r_y <= i_second_pos;
        end
        if (i_cmd.div_cap) begin
            case (i_cmd.div_op)
                tmpe_pkg::OP_X_BY_COLS: begin
                    r_qx <= n_quot;
                    r_cx <= n_rem;
                end
                tmpe_pkg::OP_Y_BY_COLS: begin
                    r_qy <= n_quot;
                    r_cy <= n_rem;
                end
                tmpe_pkg::OP_X_ROW_MOD: r_rx <= n_rem;
                default:                r_ry <= n_rem;
            endcase
        end
    end

    // route choice per leg; a tie takes the wrap route
    always_comb begin
        n_rlo = (r_rx < r_ry) ? r_rx : r_ry;
        n_rhi = (r_rx < r_ry) ? r_ry : r_rx;
        n_clo = (r_cx < r_cy) ? r_cx : r_cy;
        n_chi = (r_cx < r_cy) ? r_cy : r_cx;
        n_vd2 = {n_rhi - n_rlo, 1'b0};
        n_hd2 = {n_chi - n_clo, 1'b0};
        n_vdir = n_vd2 < {1'b0, n_nr};
        n_hdir = n_hd2 < {1'b0, n_nc};
        if (n_vdir) begin
            n_st[0] = n_rlo + 1'b1;
            n_en[0] = n_rhi + 1'b1;
            n_st[1] = '0;
            n_en[1] = '0;
        end else begin
            n_st[0] = '0;
            n_en[0] = n_rlo + 1'b1;
            n_st[1] = n_rhi + 1'b1;
            n_en[1] = n_nr;
        end
        if (n_hdir) begin
            n_st[2] = n_clo;
            n_en[2] = n_chi;
            n_st[3] = '0;
            n_en[3] = '0;
        end else begin
            n_st[2] = '0;
            n_en[2] = n_clo;
            n_st[3] = n_chi;
            n_en[3] = n_nc;
        end
        n_hbase = (V_W'(n_nr) + V_W'(r_rx)) * V_W'(n_nc);
    end

    // index of the current step: column walk, then offset row walk
    always_comb begin
        if (r_seg[1]) begin
            n_val = r_hbase + V_W'(r_k);
        end else begin
            n_val = V_W'(r_k) * V_W'(n_nc) + V_W'(r_cy);
        end
    end

    // segment walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            for (int i = 0; i < 4; i++) begin
                r_st[i] <= n_st[i];
                r_en[i] <= n_en[i];
            end
            r_k     <= n_st[0];
            r_seg   <= '0;
            r_hbase <= n_hbase;
        end else if (i_cmd.adv) begin
            for (int i = 0; i < 3; i++) begin
                r_st[i] <= r_st[i+1];
                r_en[i] <= r_en[i+1];
            end
            r_k   <= r_st[1];
            r_seg <= r_seg + 1'b1;
        end else if (i_cmd.step) begin
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.step) begin
            r_pend <= n_val[QW-1:0];
        end
        if (i_cmd.step || i_cmd.flush) begin
            r_out <= r_pend;
        end
    end

    // result count, hold and output strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            r_out_v    <= 1'b0;
            r_out_last <= 1'b0;
            if (i_cmd.setup) begin
                r_cnt    <= '0;
                r_pend_v <= 1'b0;
            end else if (i_cmd.step) begin
                r_cnt    <= r_cnt + 1'b1;
                r_pend_v <= 1'b1;
                r_out_v  <= r_pend_v;
            end else if (i_cmd.flush) begin
                r_pend_v   <= 1'b0;
                r_out_v    <= r_pend_v;
                r_out_last <= r_pend_v;
            end
        end
    end

    assign o_sts.div_done = n_done;
    assign o_sts.has      = r_k < r_en[0];
    assign o_sts.last_seg = r_seg == 2'd3;
    assign o_sts.full     = r_cnt == CW'(tmpe_pkg::MAX_RESULTS);

    assign o_valid       = r_out_v;
    assign o_qubit_index = r_out;
    assign o_last        = r_out_last;

    `TMPE_ASSERT_IMP(a_last_strobed, i_clk, i_rst_n, o_last, o_valid, "last flag without strobe")
    `TMPE_ASSERT_IMP(a_more_pending, i_clk, i_rst_n, o_valid && !o_last, r_pend_v, "non-final result without a successor")
    `TMPE_ASSERT_ALWAYS(a_cnt_cap, i_clk, i_rst_n, r_cnt <= CW'(tmpe_pkg::MAX_RESULTS), "result count above cap")

endmodule

### hw/rtl/tmpe_ctrl.sv
// controller state machine: sequences divides, route setup, stepping and flush
// depends on tmpe_pkg and the assertion macro header
`include "toroidal_min_path_emitter_core_macros.svh"

module tmpe_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  tmpe_pkg::t_sts i_sts,
    output tmpe_pkg::t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DIV_GO   = 6'b000010,
        S_DIV_WAIT = 6'b000100,
        S_SETUP    = 6'b001000,
        S_EMIT     = 6'b010000,
        S_FLUSH    = 6'b100000
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_op;
    logic [1:0] n_op;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        o_cmd.div_op = r_op;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_op       = tmpe_pkg::OP_X_BY_COLS;
                    n_state    = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_cap = 1'b1;
                    if (r_op == tmpe_pkg::OP_Y_ROW_MOD) begin
                        n_state = S_SETUP;
                    end else begin
                        n_op    = r_op + 1'b1;
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.full) begin
                    n_state = S_FLUSH;
                end else if (i_sts.has) begin
                    o_cmd.step = 1'b1;
                end else if (i_sts.last_seg) begin
                    n_state = S_FLUSH;
                end else begin
                    o_cmd.adv = 1'b1;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= tmpe_pkg::OP_X_BY_COLS;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign busy = r_state != S_IDLE;

    `TMPE_ASSERT_IMP(a_done_in_wait, i_clk, i_rst_n, i_sts.div_done, r_state == S_DIV_WAIT, "divider done outside wait")
    `TMPE_ASSERT_IMP(a_step_ok, i_clk, i_rst_n, o_cmd.step, i_sts.has && !i_sts.full, "step past segment end or cap")
    `TMPE_ASSERT_NEXT(a_start_div, i_clk, i_rst_n, start && !busy, r_state == S_DIV_GO, "accepted transaction did not start a divide")

endmodule

### hw/rtl/toroidal_min_path_emitter_core.sv
// top level of the toroidal shortest correction path emitter
// depends on tmpe_pkg, tmpe_ctrl and tmpe_dp
//
//   channel   handshake            payload
//   --------  -------------------  ------------------------------------
//   config    i_cfg_we             i_cfg_idx, i_cfg_data
//   request   start, busy          i_first_pos, i_second_pos
//   result    o_valid (strobe)     o_qubit_index, o_last
//
// busy stays high from the accepting edge through four passes of the shared
// 10-step divider (position split by columns, then row reduction), the route
// setup, the emission of the results with up to 3 route segment switches,
// one end check and the flush.
// reset is synchronous, active low; config returns to 8 rows and 8 columns.
// results are strobed for one cycle each and cannot be stalled; the final one
// is strobed in the first cycle with busy low again.
// a path with identical positions gives no result.
module toroidal_min_path_emitter_core #(
    parameter int MAX_ROWS = tmpe_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = tmpe_pkg::DEF_MAX_COLS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tmpe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tmpe_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [tmpe_pkg::POS_W-1:0]     i_first_pos,
    input  logic [tmpe_pkg::POS_W-1:0]     i_second_pos,
    output logic                           o_valid,
    output logic [tmpe_pkg::QIDX_W-1:0]    o_qubit_index,
    output logic                           o_last
);

    tmpe_pkg::t_cmd cmd;
    tmpe_pkg::t_sts sts;

    // controller
    tmpe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath
    tmpe_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_first_pos   (i_first_pos),
        .i_second_pos  (i_second_pos),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_qubit_index (o_qubit_index),
        .o_last        (o_last)
    );

endmodule
